// File: design/assert_macros.svh
// Assertion macros shared by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GFBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define GFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/gfba_pkg.sv
// Shared types and constants for the grouped free-block allocator
`timescale 1ns / 1ps

package gfba_pkg;

	localparam int FREE_W   = 11;
	localparam int ALLOC_W  = 10;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Group transfer request from the stack controller
	typedef struct packed {
		logic spill;
		logic reload;
	} xfer_cmd_t;

	// Group transfer side effects on the in-core stack
	typedef struct packed {
		logic stk_we;
		logic link_we;
		logic done;
	} xfer_ctl_t;

endpackage

// File: design/gfba_xfer.sv
// Group store memory and the sequencer that spills or reloads one group
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gfba_xfer
	import gfba_pkg::*;
#(
	parameter int STACK_DEPTH = 16,
	parameter int DATA_BLOCKS = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  xfer_cmd_t                            cmd,
	input  logic [$clog2(DATA_BLOCKS)-1:0]       slot,
	input  logic [$clog2(DATA_BLOCKS+1)-1:0]     link_in,
	input  logic [$clog2(DATA_BLOCKS+1)-1:0]     stk_rd_data,
	output logic [$clog2(STACK_DEPTH)-1:0]       stk_raddr,
	output logic [$clog2(STACK_DEPTH)-1:0]       stk_waddr,
	output logic [$clog2(DATA_BLOCKS+1)-1:0]     stk_wdata,
	output xfer_ctl_t                            ctl
);

	localparam int IW    = $clog2(STACK_DEPTH);
	localparam int EW    = $clog2(DATA_BLOCKS+1);
	localparam int SW    = $clog2(DATA_BLOCKS);
	localparam int GDEPTH = DATA_BLOCKS << IW;
	localparam logic [IW-1:0] LAST = IW'(STACK_DEPTH - 1);

	typedef enum logic [2:0] {
		X_IDLE   = 3'b001,
		X_SPILL  = 3'b010,
		X_RELOAD = 3'b100
	} xmode_t;

	xmode_t           mode_q;
	logic [IW-1:0]    cnt_q;
	logic [SW-1:0]    slot_q;
	logic [EW-1:0]    gmem [0:GDEPTH-1];
	logic [EW-1:0]    grd_q;
	logic             g_we;
	logic [SW+IW-1:0] g_waddr;
	logic [EW-1:0]    g_wdata;
	logic [SW+IW-1:0] g_raddr;
	logic [IW-1:0]    cnt_nx;

	assign cnt_nx = cnt_q + IW'(1);

	// Select group store port addresses for the current step
	always_comb begin
		g_we    = 1'b0;
		g_waddr = {slot, IW'(0)};
		g_wdata = link_in;
		g_raddr = {slot, IW'(0)};
		unique case (mode_q)
			X_IDLE: begin
				g_we = cmd.spill;
			end
			X_SPILL: begin
				g_we    = 1'b1;
				g_waddr = {slot_q, cnt_q};
				g_wdata = stk_rd_data;
				g_raddr = {slot_q, cnt_nx};
			end
			X_RELOAD: begin
				g_raddr = {slot_q, cnt_nx};
			end
			default: begin
				g_we = 1'b0;
			end
		endcase
	end

	// Group store: one write port, registered read
	always_ff @(posedge clk) begin
		if (g_we) begin
			gmem[g_waddr] <= g_wdata;
		end
		grd_q <= gmem[g_raddr];
	end

	// Advance the entry counter through one group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= X_IDLE;
			cnt_q  <= '0;
			slot_q <= '0;
		end else begin
			unique case (mode_q)
				X_IDLE: begin
					slot_q <= slot;
					if (cmd.spill) begin
						mode_q <= X_SPILL;
						cnt_q  <= IW'(1);
					end else if (cmd.reload) begin
						mode_q <= X_RELOAD;
						cnt_q  <= '0;
					end
				end
				X_SPILL, X_RELOAD: begin
					if (cnt_q == LAST) begin
						mode_q <= X_IDLE;
					end else begin
						cnt_q <= cnt_nx;
					end
				end
				default: begin
					mode_q <= X_IDLE;
				end
			endcase
		end
	end

	// Drive the stack-side read address, writes while reloading, link load and done
	assign stk_raddr   = cnt_nx;
	assign stk_waddr   = cnt_q;
	assign stk_wdata   = grd_q;
	assign ctl.stk_we  = (mode_q == X_RELOAD) && (cnt_q != '0);
	assign ctl.link_we = (mode_q == X_RELOAD) && (cnt_q == '0);
	assign ctl.done    = (mode_q != X_IDLE) && (cnt_q == LAST);

	`GFBA_ASSERT_IMPL(a_cmd_when_idle, clk, arst_n, cmd.spill || cmd.reload, mode_q == X_IDLE, "transfer command while a group transfer runs")
	`GFBA_ASSERT_NEXT(a_done_ends, clk, arst_n, ctl.done, mode_q == X_IDLE, "group transfer did not end after done")

endmodule

// File: design/grouped_free_block_allocator.sv
// Grouped free-block allocator: in-core free stack with spill/reload through a group store.
// Free, rejected free, empty allocate, reload allocate: result registered in the cycle after accept.
// Pop allocate: the stack memory read is registered in S_POP, then the result register loads;
// the next item waits for the pop. A spill or a reload holds off input while the group transfer runs.
// Throughput: 1 item/cycle for frees while no spill runs and the result side is not stalled.
// Reset: stack link = none, fill 1, count 0; group store is not cleared (no clearing pass).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grouped_free_block_allocator
	import gfba_pkg::*;
#(
	parameter int STACK_DEPTH = 16,
	parameter int DATA_BLOCKS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [FREE_W-1:0]   free_block,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [ALLOC_W-1:0]  alloc_block,
	output logic [STATUS_W-1:0] status,
	output logic [COUNT_W-1:0]  free_total
);

	localparam int IW    = $clog2(STACK_DEPTH);
	localparam int FW    = $clog2(STACK_DEPTH+1);
	localparam int EW    = $clog2(DATA_BLOCKS+1);
	localparam int SW    = $clog2(DATA_BLOCKS);
	localparam int STK_N = 1 << IW;
	localparam logic [EW-1:0] NONE_MARK = EW'(DATA_BLOCKS);
	localparam logic [FW-1:0] FILL_FULL = FW'(STACK_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_POP  = 3'b010,
		S_XFER = 3'b100
	} state_t;

	state_t               state_q;
	logic [FW-1:0]        fill_q;
	logic [COUNT_W-1:0]   count_q;
	logic [EW-1:0]        link_q;
	logic [EW-1:0]        stk_mem [0:STK_N-1];
	logic [EW-1:0]        stk_rd_q;
	logic                 out_valid_q;
	logic [ALLOC_W-1:0]   alloc_q;
	logic [STATUS_W-1:0]  status_q;
	logic [COUNT_W-1:0]   total_q;

	logic                 accept;
	logic                 out_take;
	logic                 is_free;
	logic                 range_bad;
	logic                 do_push;
	logic                 do_spill;
	logic                 do_pop;
	logic                 do_reload;
	logic [EW-1:0]        blk;
	logic [COUNT_W-1:0]   cnt_inc;
	logic [COUNT_W-1:0]   cnt_dec;
	logic [FW-1:0]        reload_fill;

	logic                 stk_we;
	logic [IW-1:0]        stk_waddr;
	logic [EW-1:0]        stk_wdata;
	logic [IW-1:0]        stk_raddr;

	xfer_cmd_t            xcmd;
	xfer_ctl_t            xctl;
	logic [SW-1:0]        xslot;
	logic [IW-1:0]        x_raddr;
	logic [IW-1:0]        x_waddr;
	logic [EW-1:0]        x_wdata;

	// Handshake: take an item only when idle and the result register can move
	assign out_take = out_valid_q && !out_stall;
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	// Decode the operation against the current stack
	assign is_free   = (op == OP_FREE);
	assign range_bad = is_free && (32'(free_block) >= DATA_BLOCKS);
	assign do_push   = is_free && !range_bad && (fill_q < FILL_FULL);
	assign do_spill  = is_free && !range_bad && (fill_q >= FILL_FULL);
	assign do_pop    = !is_free && (fill_q > FW'(1));
	assign do_reload = !is_free && (fill_q <= FW'(1)) && (link_q != NONE_MARK);
	assign blk       = EW'(free_block);

	// Saturating free count
	assign cnt_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
	assign cnt_dec = (count_q == '0) ? count_q : count_q - COUNT_W'(1);

	// Fill after reload: short last group takes the remaining count
	always_comb begin
		if (link_q != NONE_MARK) begin
			reload_fill = FILL_FULL;
		end else if (32'(count_q) >= STACK_DEPTH - 1) begin
			reload_fill = FILL_FULL;
		end else begin
			reload_fill = FW'(count_q) + FW'(1);
		end
	end

	// Start group transfers
	assign xcmd.spill  = accept && do_spill;
	assign xcmd.reload = accept && do_reload;
	assign xslot       = is_free ? SW'(free_block) : SW'(link_q);

	gfba_xfer #(
		.STACK_DEPTH (STACK_DEPTH),
		.DATA_BLOCKS (DATA_BLOCKS)
	) u_xfer (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (xcmd),
		.slot        (xslot),
		.link_in     (link_q),
		.stk_rd_data (stk_rd_q),
		.stk_raddr   (x_raddr),
		.stk_waddr   (x_waddr),
		.stk_wdata   (x_wdata),
		.ctl         (xctl)
	);

	// Stack memory ports: push or reload write, pop or spill read
	always_comb begin
		stk_we    = xctl.stk_we;
		stk_waddr = x_waddr;
		stk_wdata = x_wdata;
		if (accept && do_push) begin
			stk_we    = 1'b1;
			stk_waddr = fill_q[IW-1:0];
			stk_wdata = blk;
		end
		if (state_q == S_XFER) begin
			stk_raddr = x_raddr;
		end else if (is_free) begin
			stk_raddr = IW'(1);
		end else begin
			stk_raddr = IW'(fill_q - FW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

	// Control state: sequencer, fill, count, link
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= FW'(1);
			count_q <= '0;
			link_q  <= NONE_MARK;
		end else begin
			if (xctl.link_we) begin
				link_q <= x_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (do_push) begin
							fill_q  <= fill_q + FW'(1);
							count_q <= cnt_inc;
						end else if (do_spill) begin
							fill_q  <= FW'(1);
							count_q <= cnt_inc;
							link_q  <= blk;
							state_q <= S_XFER;
						end else if (do_pop) begin
							fill_q  <= fill_q - FW'(1);
							count_q <= cnt_dec;
							state_q <= S_POP;
						end else if (do_reload) begin
							count_q <= cnt_dec;
							state_q <= S_XFER;
						end
					end
				end
				S_POP: begin
					state_q <= S_IDLE;
				end
				S_XFER: begin
					if (xctl.done) begin
						state_q <= S_IDLE;
						if (xctl.stk_we) begin
							fill_q <= reload_fill;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register valid: set on a new result, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && !do_pop) || (state_q == S_POP)) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == S_POP) begin
			alloc_q  <= ALLOC_W'(stk_rd_q);
			status_q <= ST_OK;
			total_q  <= count_q;
		end else if (accept && !do_pop) begin
			alloc_q  <= '0;
			status_q <= ST_OK;
			total_q  <= count_q;
			if (range_bad) begin
				status_q <= ST_RANGE;
			end else if (is_free) begin
				total_q <= cnt_inc;
			end else if (do_reload) begin
				alloc_q <= ALLOC_W'(link_q);
				total_q <= cnt_dec;
			end else begin
				status_q <= ST_EMPTY;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign alloc_block = alloc_q;
	assign status      = status_q;
	assign free_total  = total_q;

	`GFBA_ASSERT_IMPL(a_fill_range, clk, arst_n, 1'b1, (fill_q != '0) && (fill_q <= FILL_FULL), "stack fill out of range")
	`GFBA_ASSERT_NEXT(a_pop_reads, clk, arst_n, accept && do_pop, state_q == S_POP, "pop accepted without a read cycle")
	`GFBA_ASSERT_IMPL(a_pop_out_free, clk, arst_n, state_q == S_POP, !out_valid_q, "pop result would overwrite a pending transaction")

endmodule

// File: tb/grouped_free_block_allocator_tb.sv
// Self-checking testbench for the grouped free-block allocator with a built-in free-list predictor
`timescale 1ns / 1ps

module grouped_free_block_allocator_tb;
	import gfba_pkg::*;

	localparam int STACK_DEPTH  = 16;
	localparam int DATA_BLOCKS  = 1024;
	localparam int RANDOM_ITEMS = 1000;
	localparam int FILL_FREES   = 300;
	localparam int DRAIN_ALLOCS = 450;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 4;

	localparam logic [FREE_W-1:0] NONE_MARK = FREE_W'(DATA_BLOCKS);

	typedef struct packed {
		logic              op;
		logic [FREE_W-1:0] blk;
	} request_t;

	typedef struct packed {
		logic [ALLOC_W-1:0]  block;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  total;
	} reply_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic                op         = OP_ALLOC;
	logic [FREE_W-1:0]   free_block = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [ALLOC_W-1:0]  alloc_block;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  free_total;

	// Predicted allocator state
	logic [FREE_W-1:0]  fl_stack [STACK_DEPTH];
	int unsigned        fl_fill;
	logic [COUNT_W-1:0] fl_count;
	logic [FREE_W-1:0]  fl_groups [STACK_DEPTH * DATA_BLOCKS];

	request_t requests_todo [$];
	reply_t   replies_due [$];

	int fault_count  = 0;
	int cycle_count  = 0;
	int burst_left   = 1;
	int gap_left     = 0;
	int stall_mode   = 0;
	int stall_span   = 0;
	int stall_hold   = 0;

	request_t next_req;
	reply_t   new_reply;
	reply_t   want;

	grouped_free_block_allocator #(
		.STACK_DEPTH(STACK_DEPTH),
		.DATA_BLOCKS(DATA_BLOCKS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.free_block(free_block),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.alloc_block(alloc_block),
		.status(status),
		.free_total(free_total)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Advance the predicted free list by one transaction and return its reply
	task automatic free_list_step(input logic req_op, input logic [FREE_W-1:0] blk,
			output reply_t r);
		int unsigned base;
		r.block  = '0;
		r.status = ST_OK;
		if (req_op == OP_FREE) begin
			if (blk >= DATA_BLOCKS) begin
				r.status = ST_RANGE;
			end else begin
				if (fl_count < COUNT_MAX)
					fl_count = fl_count + 1'b1;
				if (fl_fill >= STACK_DEPTH) begin
					// spill the full stack into the freed block's group slot
					base = int'(blk) * STACK_DEPTH;
					for (int i = 0; i < STACK_DEPTH; i++)
						fl_groups[base + i] = fl_stack[i];
					fl_stack[0] = blk;
					fl_fill = 1;
				end else begin
					fl_stack[fl_fill] = blk;
					fl_fill++;
				end
			end
		end else if (fl_fill > 1) begin
			fl_fill--;
			if (fl_count > 0)
				fl_count = fl_count - 1'b1;
			r.block = fl_stack[fl_fill][ALLOC_W-1:0];
		end else if (fl_stack[0] != NONE_MARK) begin
			// hand out the link block and reload its group
			r.block = fl_stack[0][ALLOC_W-1:0];
			if (fl_count > 0)
				fl_count = fl_count - 1'b1;
			base = int'(fl_stack[0]) * STACK_DEPTH;
			for (int i = 0; i < STACK_DEPTH; i++)
				fl_stack[i] = fl_groups[base + i];
			if (fl_stack[0] == NONE_MARK)
				fl_fill = (int'(fl_count) + 1 > STACK_DEPTH) ? STACK_DEPTH
					: int'(fl_count) + 1;
			else
				fl_fill = STACK_DEPTH;
		end else begin
			r.status = ST_EMPTY;
		end
		r.total = fl_count;
	endtask

	task automatic queue_request(input logic req_op, input int blk);
		request_t q;
		q.op  = req_op;
		q.blk = FREE_W'(blk);
		requests_todo.push_back(q);
	endtask

	// Build the whole stimulus up front
	initial begin
		int phase_len;
		int free_pct;
		int n;
		// directed: empty allocate, range edges, pops, spill, reload at chain end
		queue_request(OP_ALLOC, 2047);
		queue_request(OP_FREE, 2047);
		queue_request(OP_FREE, DATA_BLOCKS);
		queue_request(OP_FREE, 0);
		queue_request(OP_FREE, DATA_BLOCKS - 1);
		queue_request(OP_ALLOC, 0);
		queue_request(OP_ALLOC, 1365);
		queue_request(OP_ALLOC, 682);
		for (int i = 0; i < STACK_DEPTH; i++)
			queue_request(OP_FREE, (i * 341 + 682) % DATA_BLOCKS);
		queue_request(OP_ALLOC, 0);
		queue_request(OP_ALLOC, 2047);

		// random phases with shifting free/allocate balance
		n = 0;
		while (n < RANDOM_ITEMS) begin
			phase_len = $urandom_range(40, 160);
			case ($urandom_range(0, 3))
				0: free_pct = 15;
				1: free_pct = 50;
				2: free_pct = 70;
				default: free_pct = 90;
			endcase
			for (int k = 0; k < phase_len && n < RANDOM_ITEMS; k++) begin
				if ($urandom_range(0, 99) < free_pct) begin
					if ($urandom_range(0, 15) == 0)
						queue_request(OP_FREE, $urandom_range(DATA_BLOCKS, 2047));
					else
						queue_request(OP_FREE, $urandom_range(0, DATA_BLOCKS - 1));
				end else begin
					queue_request(OP_ALLOC, $urandom_range(0, 2047));
				end
				n++;
			end
		end

		// pile up free blocks, then allocate a long run through the reload chain
		for (int k = 0; k < FILL_FREES; k++)
			queue_request(OP_FREE, $urandom_range(0, DATA_BLOCKS - 1));
		for (int k = 0; k < DRAIN_ALLOCS; k++)
			queue_request(OP_ALLOC, $urandom_range(0, 2047));
	end

	// Reset once, then wait for the stimulus to drain
	initial begin
		fl_stack[0] = NONE_MARK;
		for (int i = 1; i < STACK_DEPTH; i++)
			fl_stack[i] = '0;
		fl_fill  = 1;
		fl_count = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (requests_todo.size() != 0 || in_valid || replies_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (replies_due.size() != 0) begin
			$display("%0t: %0d expected replies never arrived", $time, replies_due.size());
			fault_count++;
		end
		if (fault_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Drive requests in bursts with random gaps; predict each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			op         <= OP_ALLOC;
			free_block <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				free_list_step(op, free_block, new_reply);
				replies_due.push_back(new_reply);
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (requests_todo.size() != 0) begin
					next_req = requests_todo.pop_front();
					in_valid   <= 1'b1;
					op         <= next_req.op;
					free_block <= next_req.blk;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Stall the result side on a pattern that changes mode now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_span == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_span = $urandom_range(64, 256);
			end else begin
				stall_span--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: begin
					if (stall_hold > 0) begin
						stall_hold--;
						out_stall <= 1'b1;
					end else if ($urandom_range(0, 7) == 0) begin
						stall_hold = $urandom_range(1, 10);
						out_stall <= 1'b1;
					end else begin
						out_stall <= 1'b0;
					end
				end
			endcase
		end
	end

	task automatic report_field(input string name, input int exp_val, input int act_val);
		fault_count++;
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val,
			act_val);
	endtask

	// Check each accepted reply against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				fault_count++;
				$display("%0t: unexpected reply: block %0d status %0d total %0d", $time,
					alloc_block, status, free_total);
			end else begin
				want = replies_due.pop_front();
				if (alloc_block !== want.block)
					report_field("alloc_block", want.block, alloc_block);
				if (status !== want.status)
					report_field("status", want.status, status);
				if (free_total !== want.total)
					report_field("free_total", want.total, free_total);
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
